/* src/chp_pkg.sv */
// Package with shared constants and types of the convex hull block.
package chp_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int REL_W      = COORD_BITS + 1;
   localparam int PROD_W     = 2 * REL_W;
   localparam int DIST_W     = PROD_W + 1;
   localparam int DIFF_W     = REL_W + 1;
   localparam int TURN_W     = 2 * DIFF_W;

   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic signed [REL_W-1:0] dx;
      logic signed [REL_W-1:0] dy;
      logic [DIST_W-1:0]       dsq;
      logic                    cat;
   } key_type;

   typedef struct packed {
      logic clear;
      logic mul;
      logic ins;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic signed [REL_W-1:0] dx;
      logic signed [REL_W-1:0] dy;
   } stk_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } pt_type;

endpackage

/* src/chp_cell.sv */
// One cell of the angular sort chain: holds one point and compares it with the broadcast key.
module chp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  chp_pkg::cell_ctl_type ctl,
   input  chp_pkg::key_type      key,
   input  chp_pkg::key_type      prev_entry,
   input  logic                  prev_valid,
   input  logic                  prev_lt,
   input  chp_pkg::key_type      next_entry,
   input  logic                  next_valid,
   output chp_pkg::key_type      entry,
   output logic                  valid,
   output logic                  lt
);

   chp_pkg::key_type                     entry_ff, entry_in;
   logic                                 valid_ff, valid_in;
   logic signed [chp_pkg::PROD_W-1:0]    l_ff, r_ff;
   logic                                 prec;

   always_comb begin
      if (key.cat != entry_ff.cat) begin
         prec = !key.cat && entry_ff.cat;
      end else if (!key.cat && (l_ff != r_ff)) begin
         prec = l_ff > r_ff;
      end else begin
         prec = key.dsq < entry_ff.dsq;
      end
      lt = !valid_ff || prec;
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.ins) begin
         if (prev_lt) begin
            entry_in = prev_entry;
            valid_in = prev_valid;
         end else if (lt) begin
            entry_in = key;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
      if (ctl.mul) begin
         l_ff <= key.dx * entry_ff.dy;
         r_ff <= key.dy * entry_ff.dx;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

   property p_shift_keeps_order;
      @(posedge clock) disable iff (reset)
      (ctl.shift && !next_valid) |=> !valid_ff;
   endproperty
   a_shift_keeps_order: assert property (p_shift_keeps_order)
      else $error("cell valid after shifting in an empty neighbor");

   property p_insert_fills;
      @(posedge clock) disable iff (reset)
      (ctl.ins && !prev_lt && lt) |=> (valid_ff && entry_ff.idx == $past(key.idx));
   endproperty
   a_insert_fills: assert property (p_insert_fills)
      else $error("key not taken by the cell that should hold it");

   property p_clear;
      @(posedge clock) disable iff (reset)
      ctl.clear |=> !valid_ff;
   endproperty
   a_clear: assert property (p_clear)
      else $error("cell not cleared");

endmodule

/* src/convex_hull_point_set.sv */
// Top level of the convex hull block: point store, sort chain, scan stack and result output.
// Requests are accepted only while busy is low; after the last request the block sorts each
// non-pivot point by broadcast insertion into the cell chain, scans the sorted points with a
// stack that pops points making a right turn, and then emits the hull points one at a time.
// Throughput is set by the shared insertion step and the scan stack, which has one write port.
// Reset clears the control state and the cell valid bits; the point and stack memories are not
// cleared, and results cannot be stalled by the receiver.
module convex_hull_point_set (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [chp_pkg::COORD_BITS-1:0]  req_point_x,
   input  logic signed [chp_pkg::COORD_BITS-1:0]  req_point_y,
   input  logic                                   req_last_point,
   output logic                                   rsp_strobe,
   output logic [chp_pkg::IDX_W-1:0]              rsp_hull_index,
   output logic                                   rsp_last_hull,
   output logic                                   rsp_overflowed
);

   typedef enum logic [3:0] {
      S_LOAD, S_FD_RD, S_FD_SUB, S_FD_SQ, S_FD_KEY, S_CL_MUL, S_CL_INS,
      S_SC_PIV, S_SC_RD, S_SC_SUB, S_SC_MUL, S_SC_CMP, S_OUT_RD, S_OUT_EMIT
   } state_type;

   localparam int N = chp_pkg::MAX_POINTS;

   state_type                               state_ff;
   logic [chp_pkg::CNT_W-1:0]               count_ff, n_ff, fi_ff, si_ff, depth_ff;
   logic                                    drop_ff, ovf_ff;
   logic [chp_pkg::IDX_W-1:0]               pivot_ff, oi_ff, kidx_ff;
   logic signed [chp_pkg::COORD_BITS-1:0]   piv_x_ff, piv_y_ff;
   logic signed [chp_pkg::REL_W-1:0]        dx_ff, dy_ff;
   logic signed [chp_pkg::PROD_W-1:0]       sqx_ff, sqy_ff;
   chp_pkg::key_type                        key_ff;
   logic signed [chp_pkg::DIFF_W-1:0]       ax_ff, ay_ff, qx_ff, qy_ff;
   logic signed [chp_pkg::TURN_W-1:0]       l_ff, r_ff;
   logic                                    rsp_strobe_ff, rsp_last_ff, rsp_ovf_ff;
   logic [chp_pkg::IDX_W-1:0]               rsp_index_ff;

   chp_pkg::pt_type                         pmem [N];
   chp_pkg::pt_type                         prd_ff;
   chp_pkg::stk_type                        stk [N];
   chp_pkg::stk_type                        sa_ff, sb_ff, stk_wd;
   logic [chp_pkg::IDX_W-1:0]               sa_addr, sb_addr, stk_wa;
   logic                                    stk_we, push, accept, store_ok;

   chp_pkg::cell_ctl_type                   ctl;
   chp_pkg::key_type                        cell_entry [N];
   logic                                    cell_valid [N];
   logic                                    cell_lt [N];
   chp_pkg::stk_type                        head;

   assign accept   = start && !busy;
   assign busy     = state_ff != S_LOAD;
   assign store_ok = count_ff < chp_pkg::CNT_W'(N);

   assign head.idx = cell_entry[0].idx;
   assign head.dx  = cell_entry[0].dx;
   assign head.dy  = cell_entry[0].dy;

   assign push = (state_ff == S_SC_RD && si_ff != n_ff && depth_ff < chp_pkg::CNT_W'(2)) ||
                 (state_ff == S_SC_CMP && !(l_ff < r_ff));

   assign ctl.clear = state_ff == S_LOAD;
   assign ctl.mul   = state_ff == S_CL_MUL;
   assign ctl.ins   = state_ff == S_CL_INS;
   assign ctl.shift = push;

   always_comb begin
      stk_we = push || state_ff == S_SC_PIV;
      if (state_ff == S_SC_PIV) begin
         stk_wd.idx = pivot_ff;
         stk_wd.dx  = '0;
         stk_wd.dy  = '0;
         stk_wa     = '0;
      end else begin
         stk_wd = head;
         stk_wa = depth_ff[chp_pkg::IDX_W-1:0];
      end
      if (state_ff == S_OUT_RD || state_ff == S_OUT_EMIT) begin
         sa_addr = oi_ff;
      end else begin
         sa_addr = chp_pkg::IDX_W'(depth_ff - chp_pkg::CNT_W'(2));
      end
      sb_addr = chp_pkg::IDX_W'(depth_ff - chp_pkg::CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (accept && store_ok) begin
         pmem[count_ff[chp_pkg::IDX_W-1:0]] <= '{x: req_point_x, y: req_point_y};
      end
      prd_ff <= pmem[fi_ff[chp_pkg::IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk[stk_wa] <= stk_wd;
      end
      sa_ff <= stk[sa_addr];
      sb_ff <= stk[sb_addr];
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      chp_pkg::key_type prev_e, next_e;
      logic             prev_l, prev_v, next_v;
      if (i == 0) begin : g_first
         assign prev_e = key_ff;
         assign prev_v = 1'b0;
         assign prev_l = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_v = cell_valid[i-1];
         assign prev_l = cell_lt[i-1];
      end
      if (i == N - 1) begin : g_last
         assign next_e = key_ff;
         assign next_v = 1'b0;
      end else begin : g_inner
         assign next_e = cell_entry[i+1];
         assign next_v = cell_valid[i+1];
      end
      chp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .prev_entry (prev_e),
         .prev_valid (prev_v),
         .prev_lt    (prev_l),
         .next_entry (next_e),
         .next_valid (next_v),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .lt         (cell_lt[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         pivot_ff      <= '0;
         depth_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (store_ok && (count_ff == '0 || req_point_y <= piv_y_ff)) begin
                     pivot_ff <= count_ff[chp_pkg::IDX_W-1:0];
                     piv_x_ff <= req_point_x;
                     piv_y_ff <= req_point_y;
                  end
                  if (req_last_point) begin
                     n_ff     <= store_ok ? count_ff + chp_pkg::CNT_W'(1) : count_ff;
                     ovf_ff   <= drop_ff || !store_ok;
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     fi_ff    <= '0;
                     state_ff <= S_FD_RD;
                  end else if (store_ok) begin
                     count_ff <= count_ff + chp_pkg::CNT_W'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
               end
            end
            S_FD_RD: begin
               if (fi_ff == n_ff) begin
                  state_ff <= S_SC_PIV;
               end else if (fi_ff[chp_pkg::IDX_W-1:0] == pivot_ff) begin
                  fi_ff <= fi_ff + chp_pkg::CNT_W'(1);
               end else begin
                  state_ff <= S_FD_SUB;
               end
            end
            S_FD_SUB: begin
               dx_ff    <= chp_pkg::REL_W'(prd_ff.x) - chp_pkg::REL_W'(piv_x_ff);
               dy_ff    <= chp_pkg::REL_W'(prd_ff.y) - chp_pkg::REL_W'(piv_y_ff);
               kidx_ff  <= fi_ff[chp_pkg::IDX_W-1:0];
               fi_ff    <= fi_ff + chp_pkg::CNT_W'(1);
               state_ff <= S_FD_SQ;
            end
            S_FD_SQ: begin
               sqx_ff   <= dx_ff * dx_ff;
               sqy_ff   <= dy_ff * dy_ff;
               state_ff <= S_FD_KEY;
            end
            S_FD_KEY: begin
               key_ff.idx <= kidx_ff;
               key_ff.dx  <= dx_ff;
               key_ff.dy  <= dy_ff;
               key_ff.dsq <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
               key_ff.cat <= (dy_ff == '0) && dx_ff[chp_pkg::REL_W-1];
               state_ff   <= S_CL_MUL;
            end
            S_CL_MUL: begin
               state_ff <= S_CL_INS;
            end
            S_CL_INS: begin
               state_ff <= S_FD_RD;
            end
            S_SC_PIV: begin
               depth_ff <= chp_pkg::CNT_W'(1);
               si_ff    <= chp_pkg::CNT_W'(1);
               state_ff <= S_SC_RD;
            end
            S_SC_RD: begin
               if (si_ff == n_ff) begin
                  oi_ff    <= '0;
                  state_ff <= S_OUT_RD;
               end else if (push) begin
                  depth_ff <= depth_ff + chp_pkg::CNT_W'(1);
                  si_ff    <= si_ff + chp_pkg::CNT_W'(1);
               end else begin
                  state_ff <= S_SC_SUB;
               end
            end
            S_SC_SUB: begin
               ax_ff    <= chp_pkg::DIFF_W'(sb_ff.dx) - chp_pkg::DIFF_W'(sa_ff.dx);
               ay_ff    <= chp_pkg::DIFF_W'(sb_ff.dy) - chp_pkg::DIFF_W'(sa_ff.dy);
               qx_ff    <= chp_pkg::DIFF_W'(head.dx) - chp_pkg::DIFF_W'(sa_ff.dx);
               qy_ff    <= chp_pkg::DIFF_W'(head.dy) - chp_pkg::DIFF_W'(sa_ff.dy);
               state_ff <= S_SC_MUL;
            end
            S_SC_MUL: begin
               l_ff     <= ax_ff * qy_ff;
               r_ff     <= ay_ff * qx_ff;
               state_ff <= S_SC_CMP;
            end
            S_SC_CMP: begin
               if (push) begin
                  depth_ff <= depth_ff + chp_pkg::CNT_W'(1);
                  si_ff    <= si_ff + chp_pkg::CNT_W'(1);
               end else begin
                  depth_ff <= depth_ff - chp_pkg::CNT_W'(1);
               end
               state_ff <= S_SC_RD;
            end
            S_OUT_RD: begin
               state_ff <= S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_index_ff  <= sa_ff.idx;
               rsp_ovf_ff    <= ovf_ff;
               rsp_last_ff   <= {1'b0, oi_ff} == depth_ff - chp_pkg::CNT_W'(1);
               oi_ff         <= oi_ff + chp_pkg::IDX_W'(1);
               if ({1'b0, oi_ff} == depth_ff - chp_pkg::CNT_W'(1)) begin
                  state_ff <= S_LOAD;
               end else begin
                  state_ff <= S_OUT_RD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hull_index = rsp_index_ff;
   assign rsp_last_hull  = rsp_last_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   property p_strobe_from_emit;
      @(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_OUT_EMIT);
   endproperty
   a_strobe_from_emit: assert property (p_strobe_from_emit)
      else $error("result strobe outside the output phase");

   property p_count_bound;
      @(posedge clock) disable iff (reset)
      count_ff <= chp_pkg::CNT_W'(N);
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("point count beyond capacity");

   property p_depth_bound;
      @(posedge clock) disable iff (reset)
      (state_ff == S_SC_RD || state_ff == S_OUT_RD) |-> depth_ff <= si_ff;
   endproperty
   a_depth_bound: assert property (p_depth_bound)
      else $error("stack deeper than the points scanned");

   property p_head_present;
      @(posedge clock) disable iff (reset)
      (state_ff == S_SC_RD && si_ff != n_ff) |-> cell_valid[0];
   endproperty
   a_head_present: assert property (p_head_present)
      else $error("sort chain empty while points remain to scan");

endmodule

/* sim/tb_convex_hull_point_set.sv */
// Testbench for the convex hull block: directed and random point sets checked against a predictor.
`timescale 1ns / 100ps

module tb_convex_hull_point_set;

   localparam int IDLE_LIMIT  = 20000;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      logic [chp_pkg::IDX_W-1:0] idx;
      logic                      lst;
      logic                      ovf;
   } hull_point_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  start = 1'b0;
   logic                                  busy;
   logic signed [chp_pkg::COORD_BITS-1:0] req_point_x = '0;
   logic signed [chp_pkg::COORD_BITS-1:0] req_point_y = '0;
   logic                                  req_last_point = 1'b0;
   logic                                  rsp_strobe;
   logic [chp_pkg::IDX_W-1:0]             rsp_hull_index;
   logic                                  rsp_last_hull;
   logic                                  rsp_overflowed;

   hull_point_type hull_q[$];
   longint         pt_x[chp_pkg::MAX_POINTS];
   longint         pt_y[chp_pkg::MAX_POINTS];
   int             pt_count = 0;
   bit             pt_dropped = 0;
   int             error_count = 0;
   int             idle_cycles = 0;
   bit             burst = 0;

   convex_hull_point_set u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_last_point(req_last_point), .rsp_strobe(rsp_strobe),
      .rsp_hull_index(rsp_hull_index), .rsp_last_hull(rsp_last_hull),
      .rsp_overflowed(rsp_overflowed)
   );

   always #1 clock = ~clock;

   function automatic bit angle_before(int a, int b, int pv);
      longint ax, ay, bx, by, l, r;
      bit     ca, cb;
      ax = pt_x[a] - pt_x[pv];
      ay = pt_y[a] - pt_y[pv];
      bx = pt_x[b] - pt_x[pv];
      by = pt_y[b] - pt_y[pv];
      ca = (ay == 0 && ax < 0);
      cb = (by == 0 && bx < 0);
      if (ca != cb) return ca < cb;
      if (!ca) begin
         l = ax * by;
         r = ay * bx;
         if (l != r) return l > r;
      end
      return (ax * ax + ay * ay) < (bx * bx + by * by);
   endfunction

   function automatic bit turns_right(int o, int a, int p);
      return (pt_x[a] - pt_x[o]) * (pt_y[p] - pt_y[o]) <
             (pt_y[a] - pt_y[o]) * (pt_x[p] - pt_x[o]);
   endfunction

   // Computes the hull of the stored set and queues the expected hull points.
   task automatic build_hull();
      int             order[chp_pkg::MAX_POINTS];
      int             stack[chp_pkg::MAX_POINTS];
      int             n, pv, k, j, cur, depth;
      hull_point_type hp;
      n = pt_count;
      pv = 0;
      for (int i = 1; i < n; i++)
         if (pt_y[i] <= pt_y[pv]) pv = i;
      order[0] = pv;
      k = 1;
      for (int i = 0; i < n; i++)
         if (i != pv) begin
            order[k] = i;
            k++;
         end
      for (int i = 2; i < n; i++) begin
         cur = order[i];
         j = i;
         while (j > 1 && angle_before(cur, order[j-1], pv)) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = cur;
      end
      depth = 0;
      for (int i = 0; i < n; i++) begin
         if (i >= 2)
            while (depth >= 2 && turns_right(stack[depth-2], stack[depth-1], order[i]))
               depth--;
         stack[depth] = order[i];
         depth++;
      end
      for (int i = 0; i < depth; i++) begin
         hp.idx = stack[i][chp_pkg::IDX_W-1:0];
         hp.lst = (i == depth - 1);
         hp.ovf = pt_dropped;
         hull_q.push_back(hp);
      end
   endtask

   task automatic send_point(logic signed [chp_pkg::COORD_BITS-1:0] x,
                             logic signed [chp_pkg::COORD_BITS-1:0] y, bit last);
      int gap;
      req_point_x <= x;
      req_point_y <= y;
      req_last_point <= last;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (pt_count < chp_pkg::MAX_POINTS) begin
         pt_x[pt_count] = x;
         pt_y[pt_count] = y;
         pt_count++;
      end else begin
         pt_dropped = 1;
      end
      if (last) begin
         if (pt_count > 0) build_hull();
         pt_count = 0;
         pt_dropped = 0;
      end
      if ($urandom_range(0, 19) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (hull_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      hull_point_type hp;
      if (!reset && rsp_strobe) begin
         if (hull_q.size() == 0) begin
            report_mismatch("unexpected hull point", rsp_hull_index, -1);
         end else begin
            hp = hull_q.pop_front();
            if (rsp_hull_index !== hp.idx) report_mismatch("hull_index", rsp_hull_index, hp.idx);
            if (rsp_last_hull !== hp.lst) report_mismatch("last_hull", rsp_last_hull, hp.lst);
            if (rsp_overflowed !== hp.ovf) report_mismatch("overflowed", rsp_overflowed, hp.ovf);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_convex_hull_point_set: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_small_sets();
      send_point(16'sd5, -16'sd7, 1'b1);
      send_point(16'sd3, 16'sd3, 1'b0);
      send_point(-16'sd2, 16'sd3, 1'b1);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd4, 16'sd4, 1'b0);
      send_point(16'sd8, 16'sd8, 1'b1);
   endtask

   task automatic test_square_with_ties();
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd10, 1'b0);
      send_point(16'sd5, 16'sd5, 1'b0);
      send_point(16'sd0, 16'sd10, 1'b0);
      send_point(16'sd5, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd0, 1'b0);
      send_point(-16'sd4, 16'sd0, 1'b1);
   endtask

   task automatic test_extremes();
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sd32767, 16'sh8000, 1'b0);
      send_point(16'sd32767, 16'sd32767, 1'b0);
      send_point(16'sh8000, 16'sd32767, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sh8000, 16'sd0, 1'b1);
      send_point(16'sd1, 16'sd1, 1'b0);
      send_point(16'sd1, 16'sd1, 1'b0);
      send_point(16'sd1, 16'sd1, 1'b1);
   endtask

   task automatic test_capacity(int extra);
      for (int i = 0; i < chp_pkg::MAX_POINTS + extra; i++)
         send_point($signed(16'($urandom_range(0, 65535))),
                    $signed(16'($urandom_range(0, 65535))),
                    i == chp_pkg::MAX_POINTS + extra - 1);
   endtask

   task automatic test_random_sets(int items);
      int sent, n, span;
      sent = 0;
      while (sent < items) begin
         n = $urandom_range(1, 14);
         span = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            if (span == 0)
               send_point($signed(16'($urandom_range(0, 65535))),
                          $signed(16'($urandom_range(0, 65535))), i == n - 1);
            else
               send_point($signed(16'($urandom_range(0, 8))) - 16'sd4,
                          $signed(16'($urandom_range(0, 8))) - 16'sd4, i == n - 1);
         end
         sent += n;
         if ($urandom_range(0, 9) == 0) drain();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_sets();
      test_square_with_ties();
      test_extremes();
      drain();
      test_random_sets(100);
      test_capacity(0);
      test_capacity(3);
      test_random_sets(40);
      drain();
      if (error_count == 0)
         $display("tb_convex_hull_point_set: done, clean");
      else
         $display("tb_convex_hull_point_set: done, errors");
      $finish;
   end

endmodule
